[rtl/core/aepp_pkg.sv]
// Shared constants, payload structs and helpers for the audio envelope peak pyramid.
// Used by every file under rtl/core; depends on nothing else.
package aepp_pkg;

   localparam int LINE_LENGTH = 300;
   localparam int LEVELS      = 6;
   localparam int NUM_CELLS   = LEVELS - 1;

   localparam int SAMPLE_W = 16;
   localparam int VALUE_W  = 15;
   localparam int LEVEL_W  = 3;
   localparam int RATIO_W  = 5;
   localparam int COUNT_W  = 4;
   localparam int SUM_W    = 24;
   localparam int POS_W    = $clog2(LINE_LENGTH + 1);

   localparam logic [VALUE_W-1:0] VALUE_MAX   = '1;
   localparam logic [RATIO_W-1:0] RATIO_MIN   = RATIO_W'(2);
   localparam logic [RATIO_W-1:0] RATIO_MAX   = RATIO_W'(16);
   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(10);
   localparam logic [LEVEL_W-1:0] LEVEL_ENV   = '0;
   localparam logic               HAS_CELLS   = (NUM_CELLS > 0);

   // Line sum divided by LINE_LENGTH through a rounded-up reciprocal; exact for every
   // sum below 2**SUM_W.
   localparam int DIV_LOG   = $clog2(LINE_LENGTH);
   localparam int DIV_SHIFT = SUM_W + DIV_LOG;
   localparam int RECIP_W   = SUM_W + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(LINE_LENGTH) - 64'd1) / 64'(LINE_LENGTH));

   localparam int TQ_DEPTH = 4;
   localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
   localparam int TQ_CNT_W = $clog2(TQ_DEPTH + 1);
   localparam int OQ_DEPTH = 8;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   typedef struct packed {
      logic [VALUE_W-1:0] env;
      logic               eos;
   } line_type;

   typedef struct packed {
      logic               valid;
      logic               flush;
      logic               eos;
      logic               has_value;
      logic [VALUE_W-1:0] value;
   } token_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_index;
      logic [VALUE_W-1:0] max_value;
      logic               is_peak_report;
      logic               last_of_run;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } emit_type;

   function automatic logic [VALUE_W-1:0] value_max(input logic [VALUE_W-1:0] a,
                                                    input logic [VALUE_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

[rtl/core/aepp_if.sv]
// Valid/ready channel interfaces for samples, results and the ratio register.
// Depends on aepp_pkg for field widths.
interface aepp_req_if import aepp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       end_of_stream;

   modport source (output valid, output sample, output end_of_stream, input ready);
   modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface aepp_rsp_if import aepp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level_index;
   logic [VALUE_W-1:0] max_value;
   logic               is_peak_report;
   logic               last_of_run;

   modport source (output valid, output level_index, output max_value,
                   output is_peak_report, output last_of_run, input ready);
   modport sink   (input valid, input level_index, input max_value,
                   input is_peak_report, input last_of_run, output ready);
endinterface

interface aepp_csr_if import aepp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RATIO_W-1:0] decimation_ratio;

   modport source (output valid, output decimation_ratio, input ready);
   modport sink   (input valid, input decimation_ratio, output ready);
endinterface

[rtl/core/audio_envelope_peak_pyramid.sv]
// Audio envelope peak pyramid: top level tying the sample front end, the level row
// and the result queue together. Depends on aepp_pkg, aepp_if and all aepp_ modules.
//
// Usage. Samples arrive on req_ch, one beat per sample, with end_of_stream on the last
// one. Every LINE_LENGTH samples (or at end of stream) one level 0 envelope beat leaves
// on rsp_ch, followed one beat per cycle by every coarser level whose group closes.
// At end of stream the partial groups are flushed level by level and a final beat
// carries the global peak with is_peak_report set; last_of_run marks the final beat
// caused by one sample. csr_ch writes decimation_ratio and is always ready; write it
// only while no results are outstanding.
// Throughput: one sample per cycle. A line passes a two-stage reciprocal multiply into
// a four-entry line queue; the level 0 beat goes on from there through the result queue
// to rsp_ch, and each further level follows as it ripples down the row of LEVELS-1
// cells. One line occupies the row at a time, and an end of stream holds it through its
// cascade, flush and peak report. req_ch.ready drops while four lines sit in the
// multiply stages and the line queue: that happens when ends of stream come closer
// together than the row retires them, or when a stalled receiver lets the eight-entry
// result queue fill, which freezes the row while lines back up.
// Reset clears all state at once and sets decimation_ratio to 10; no clearing pass.
module audio_envelope_peak_pyramid
   import aepp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   aepp_req_if.sink   req_ch,
   aepp_rsp_if.source rsp_ch,
   aepp_csr_if.sink   csr_ch
);

   logic [RATIO_W-1:0] ratio_ff, ratio_eff;
   logic               tq_valid, tq_pop;
   line_type           tq_data;
   logic               oq_full, oq_push;
   result_type         oq_data;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      if (ratio_ff < RATIO_MIN) begin
         ratio_eff = RATIO_MIN;
      end else if (ratio_ff > RATIO_MAX) begin
         ratio_eff = RATIO_MAX;
      end else begin
         ratio_eff = ratio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         ratio_ff <= csr_ch.decimation_ratio;
      end
   end

   aepp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .tq_pop   (tq_pop),
      .tq_valid (tq_valid),
      .tq_data  (tq_data)
   );

   aepp_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .ratio    (ratio_eff),
      .tq_valid (tq_valid),
      .tq_data  (tq_data),
      .tq_pop   (tq_pop),
      .oq_full  (oq_full),
      .oq_push  (oq_push),
      .oq_data  (oq_data)
   );

   aepp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (oq_push),
      .push_data (oq_data),
      .full      (oq_full),
      .rsp       (rsp_ch)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      oq_push |-> !oq_full)
      else $error("result pushed into a full queue");

   a_pop_needs_line: assert property (@(posedge clock) disable iff (reset)
      tq_pop |-> tq_valid)
      else $error("line queue popped while empty");

   a_peak_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.is_peak_report) |->
         (rsp_ch.last_of_run && rsp_ch.level_index == LEVEL_ENV))
      else $error("peak report beat is not the closing level 0 beat");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result beat offered right after reset");

endmodule

[rtl/core/aepp_front.sv]
// Sample front end: magnitude accumulation per line, divide by the line length and
// a small queue of finished line envelopes. Depends on aepp_pkg and aepp_if.
module aepp_front
   import aepp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   aepp_req_if.sink         req,
   input  logic             tq_pop,
   output logic             tq_valid,
   output line_type         tq_data
);

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                s1_valid_ff, s1_valid_in;
   logic [SUM_W-1:0]    s1_sum_ff, s1_sum_in;
   logic                s1_eos_ff, s1_eos_in;
   logic                s2_valid_ff;
   logic [PROD_W-1:0]   s2_prod_ff;
   logic                s2_eos_ff;

   line_type            tq_mem_ff [TQ_DEPTH];
   logic [TQ_PTR_W-1:0] tq_wr_ff, tq_rd_ff;
   logic [TQ_CNT_W-1:0] tq_count_ff, tq_count_in;

   logic [SAMPLE_W-1:0] raw, mag_full;
   logic [VALUE_W-1:0]  mag;
   logic [SUM_W-1:0]    sum_next;
   logic [POS_W-1:0]    pos_inc;
   logic                line_end, accept;
   logic [SUM_W-1:0]    quot;
   logic [VALUE_W-1:0]  env;
   logic [TQ_CNT_W:0]   pending;

   // Lines still in the divider count against the queue so that the pipe never stalls.
   assign pending   = {1'b0, tq_count_ff} + (TQ_CNT_W+1)'(s1_valid_ff)
                      + (TQ_CNT_W+1)'(s2_valid_ff);
   assign req.ready = pending < (TQ_CNT_W+1)'(TQ_DEPTH);
   assign accept    = req.valid && req.ready;

   always_comb begin
      raw      = req.sample;
      mag_full = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
      // Only the most negative sample leaves the top bit set; it saturates.
      mag      = mag_full[SAMPLE_W-1] ? VALUE_MAX : mag_full[VALUE_W-1:0];
      sum_next = sum_ff + SUM_W'(mag);
      pos_inc  = pos_ff + 1'b1;
      line_end = (pos_inc >= POS_W'(LINE_LENGTH)) || req.end_of_stream;

      sum_in      = sum_ff;
      pos_in      = pos_ff;
      s1_valid_in = 1'b0;
      s1_sum_in   = sum_next;
      s1_eos_in   = req.end_of_stream;
      if (accept) begin
         if (line_end) begin
            s1_valid_in = 1'b1;
            sum_in      = '0;
            pos_in      = '0;
         end else begin
            sum_in = sum_next;
            pos_in = pos_inc;
         end
      end
   end

   always_comb begin
      quot = SUM_W'(s2_prod_ff >> DIV_SHIFT);
      env  = (quot > SUM_W'(VALUE_MAX)) ? VALUE_MAX : quot[VALUE_W-1:0];
   end

   always_comb begin
      tq_count_in = tq_count_ff;
      case ({s2_valid_ff, tq_pop})
         2'b10:   tq_count_in = tq_count_ff + 1'b1;
         2'b01:   tq_count_in = tq_count_ff - 1'b1;
         default: tq_count_in = tq_count_ff;
      endcase
   end

   assign tq_valid = (tq_count_ff != '0);
   assign tq_data  = tq_mem_ff[tq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         tq_wr_ff    <= '0;
         tq_rd_ff    <= '0;
         tq_count_ff <= '0;
      end else begin
         sum_ff      <= sum_in;
         pos_ff      <= pos_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         tq_count_ff <= tq_count_in;
         if (s2_valid_ff) begin
            tq_wr_ff <= tq_wr_ff + 1'b1;
         end
         if (tq_pop) begin
            tq_rd_ff <= tq_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_sum_ff  <= s1_sum_in;
      s1_eos_ff  <= s1_eos_in;
      s2_prod_ff <= s1_sum_ff * DIV_RECIP;
      s2_eos_ff  <= s1_eos_ff;
      if (s2_valid_ff) begin
         tq_mem_ff[tq_wr_ff] <= '{env: env, eos: s2_eos_ff};
      end
   end

endmodule

[rtl/core/aepp_cell.sv]
// One pyramid level: running maximum and group count, passing completed groups and
// flush tokens to the next coarser level. Depends on aepp_pkg.
module aepp_cell
   import aepp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [LEVEL_W-1:0] level,
   input  logic               is_top,
   input  logic [RATIO_W-1:0] ratio,
   input  token_type          tok_i,
   input  logic               next_completes,
   output token_type          tok_o,
   output logic               completes,
   output emit_type           em_o
);

   logic [VALUE_W-1:0] max_ff, max_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   token_type          tok_ff, tok_in;
   logic [VALUE_W-1:0] merged;
   logic [COUNT_W:0]   count_inc;

   assign count_inc = {1'b0, count_ff} + 1'b1;
   // A group closes when the incoming value brings it to the ratio in force now.
   assign completes = (count_inc >= (COUNT_W+1)'(ratio));
   assign tok_o     = tok_ff;

   always_comb begin
      merged   = tok_i.has_value ? value_max(max_ff, tok_i.value) : max_ff;
      max_in   = max_ff;
      count_in = count_ff;
      tok_in   = '0;
      em_o     = '0;
      em_o.data.level_index = level;
      em_o.data.max_value   = merged;
      if (tok_i.valid) begin
         if (tok_i.flush) begin
            em_o.valid      = tok_i.has_value || (count_ff != '0);
            tok_in.valid    = !is_top;
            tok_in.flush    = 1'b1;
            tok_in.eos      = tok_i.eos;
            tok_in.has_value = em_o.valid;
            tok_in.value    = merged;
            max_in          = '0;
            count_in        = '0;
         end else if (completes) begin
            em_o.valid            = 1'b1;
            em_o.data.last_of_run = !tok_i.eos && !next_completes;
            tok_in.valid          = !is_top;
            tok_in.eos            = tok_i.eos;
            tok_in.has_value      = 1'b1;
            tok_in.value          = merged;
            max_in                = '0;
            count_in              = '0;
         end else begin
            max_in   = merged;
            count_in = count_inc[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= '0;
         count_ff <= '0;
         tok_ff   <= '0;
      end else if (advance) begin
         max_ff   <= max_in;
         count_ff <= count_in;
         tok_ff   <= tok_in;
      end
   end

endmodule

[rtl/core/aepp_chain.sv]
// Head sequencer and the row of level cells: emits level 0 envelopes, launches cascade
// and flush tokens, tracks and reports the global peak. Depends on aepp_pkg, aepp_cell.
module aepp_chain
   import aepp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [RATIO_W-1:0] ratio,
   input  logic               tq_valid,
   input  line_type           tq_data,
   output logic               tq_pop,
   input  logic               oq_full,
   output logic               oq_push,
   output result_type         oq_data
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_CASCADE = 3'b010,
      ST_FLUSH   = 3'b100
   } head_state_type;

   head_state_type     state_ff, state_in;
   logic [VALUE_W-1:0] peak_ff, peak_in;
   token_type          tok0_ff, tok0_in;
   emit_type           em0;

   token_type tok [0:NUM_CELLS];
   emit_type  em  [0:NUM_CELLS];
   logic      cmp [1:NUM_CELLS+1];
   logic      advance, busy;

   // At most one source emits per cycle, so a free output slot lets the whole row move.
   assign advance = !oq_full;
   assign tok[0]  = tok0_ff;
   assign em[0]   = em0;
   assign cmp[NUM_CELLS+1] = 1'b0;

   for (genvar k = 1; k <= NUM_CELLS; k++) begin : g_cell
      aepp_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .advance        (advance),
         .level          (LEVEL_W'(k)),
         .is_top         (k == NUM_CELLS),
         .ratio          (ratio),
         .tok_i          (tok[k-1]),
         .next_completes (cmp[k+1]),
         .tok_o          (tok[k]),
         .completes      (cmp[k]),
         .em_o           (em[k])
      );
   end

   always_comb begin
      busy = 1'b0;
      for (int i = 0; i <= NUM_CELLS; i++) begin
         busy = busy | tok[i].valid;
      end
   end

   always_comb begin
      oq_push = 1'b0;
      oq_data = em[0].data;
      for (int i = 0; i <= NUM_CELLS; i++) begin
         if (em[i].valid) begin
            oq_push = advance;
            oq_data = em[i].data;
         end
      end
   end

   // A new line waits until the previous one has left the row, keeping results in order.
   always_comb begin
      state_in = state_ff;
      peak_in  = peak_ff;
      tok0_in  = '0;
      em0      = '0;
      tq_pop   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (tq_valid && !busy) begin
               tq_pop                = advance;
               em0.valid             = 1'b1;
               em0.data.level_index  = LEVEL_ENV;
               em0.data.max_value    = tq_data.env;
               em0.data.last_of_run  = !tq_data.eos && !cmp[1];
               peak_in               = value_max(peak_ff, tq_data.env);
               tok0_in.valid         = HAS_CELLS;
               tok0_in.eos           = tq_data.eos;
               tok0_in.has_value     = 1'b1;
               tok0_in.value         = tq_data.env;
               if (tq_data.eos) begin
                  state_in = ST_CASCADE;
               end
            end
         end
         ST_CASCADE: begin
            if (!busy) begin
               tok0_in.valid = HAS_CELLS;
               tok0_in.flush = 1'b1;
               tok0_in.eos   = 1'b1;
               state_in      = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!busy) begin
               em0.valid               = 1'b1;
               em0.data.level_index    = LEVEL_ENV;
               em0.data.max_value      = peak_ff;
               em0.data.is_peak_report = 1'b1;
               em0.data.last_of_run    = 1'b1;
               peak_in                 = '0;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         peak_ff  <= '0;
         tok0_ff  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         peak_ff  <= peak_in;
         tok0_ff  <= tok0_in;
      end
   end

endmodule

[rtl/core/aepp_outq.sv]
// Result queue between the level row and the response channel, so bursts of level
// results do not hold up sample intake. Depends on aepp_pkg and aepp_if.
module aepp_outq
   import aepp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   aepp_rsp_if.source rsp
);

   result_type          mem_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] wr_ff, rd_ff;
   logic [OQ_CNT_W-1:0] count_ff, count_in;
   logic                pop;
   result_type          head;

   assign full = (count_ff == OQ_CNT_W'(OQ_DEPTH));
   assign pop  = rsp.valid && rsp.ready;
   assign head = mem_ff[rd_ff];

   assign rsp.valid          = (count_ff != '0);
   assign rsp.level_index    = head.level_index;
   assign rsp.max_value      = head.max_value;
   assign rsp.is_peak_report = head.is_peak_report;
   assign rsp.last_of_run    = head.last_of_run;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[test/audio_envelope_peak_pyramid_tb.sv]
// Self-checking testbench for audio_envelope_peak_pyramid: sample streams in, envelope
// levels and peak reports out, checked against a predictor of the line and level logic.
// Depends on aepp_pkg, the aepp_ channel interfaces and the block's RTL.
`timescale 1ns / 100ps

module audio_envelope_peak_pyramid_tb;
   import aepp_pkg::*;

   localparam int DRAIN_CYCLES   = 2 * LEVELS + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_SAMPLES = 246;
   localparam int PRINT_LIMIT    = 40;

   logic clock = 1'b0;
   logic reset;

   aepp_req_if req_ch ();
   aepp_rsp_if rsp_ch ();
   aepp_csr_if csr_ch ();

   audio_envelope_peak_pyramid u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state, mirrored from the block's line and level logic.
   logic [SUM_W-1:0]   line_sum;
   int unsigned        line_fill;
   logic [VALUE_W-1:0] group_max [LEVELS];
   int unsigned        group_fill [LEVELS];
   logic [VALUE_W-1:0] stream_peak;
   logic [RATIO_W-1:0] ratio_reg;
   result_type         pending_envelopes [$];

   bit allow_idling = 1'b1;
   int stall_left   = 0;
   int idle_cycles  = 0;
   int error_count  = 0;
   int beats_checked = 0;
   int samples_sent = 0;
   int streams_closed = 0;
   int ratio_writes = 0;

   function automatic int group_size();
      if (ratio_reg < RATIO_MIN) return int'(RATIO_MIN);
      if (ratio_reg > RATIO_MAX) return int'(RATIO_MAX);
      return int'(ratio_reg);
   endfunction

   function automatic result_type make_result(input logic [LEVEL_W-1:0] level,
                                              input logic [VALUE_W-1:0] value,
                                              input logic               peak);
      result_type r;
      r.level_index    = level;
      r.max_value      = value;
      r.is_peak_report = peak;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   task automatic clear_stream_state();
      line_sum    = '0;
      line_fill   = 0;
      stream_peak = '0;
      for (int k = 0; k < LEVELS; k++) begin
         group_max[k]  = '0;
         group_fill[k] = 0;
      end
   endtask

   // Works out every result one accepted sample causes and queues them in order.
   task automatic predict_sample(input logic [SAMPLE_W-1:0] bits, input logic eos);
      logic [SAMPLE_W:0]  mag;
      logic [SUM_W-1:0]   quotient;
      logic [VALUE_W-1:0] env;
      logic [VALUE_W-1:0] carry;
      bit                 climbing;
      result_type         burst [$];
      mag = bits[SAMPLE_W-1] ? (17'h10000 - {1'b0, bits}) : {1'b0, bits};
      if (mag > (SAMPLE_W+1)'(VALUE_MAX)) mag = (SAMPLE_W+1)'(VALUE_MAX);
      line_sum = line_sum + SUM_W'(mag);
      line_fill++;
      if (line_fill >= LINE_LENGTH || eos) begin
         // A partial last line is still divided by the full line length.
         quotient = line_sum / SUM_W'(LINE_LENGTH);
         env = (quotient > SUM_W'(VALUE_MAX)) ? VALUE_MAX : quotient[VALUE_W-1:0];
         burst = {burst, make_result(LEVEL_ENV, env, 1'b0)};
         if (env > stream_peak) stream_peak = env;
         line_sum  = '0;
         line_fill = 0;
         carry     = env;
         climbing  = 1'b1;
         for (int k = 1; k < LEVELS && climbing; k++) begin
            if (carry > group_max[k]) group_max[k] = carry;
            group_fill[k]++;
            if (group_fill[k] < group_size()) begin
               climbing = 1'b0;
            end else begin
               carry = group_max[k];
               burst = {burst, make_result(LEVEL_W'(k), carry, 1'b0)};
               group_max[k]  = '0;
               group_fill[k] = 0;
            end
         end
      end
      if (eos) begin
         // Partial groups flush from level 1 upward, each feeding the next level.
         for (int k = 1; k < LEVELS; k++) begin
            if (group_fill[k] != 0) begin
               burst = {burst, make_result(LEVEL_W'(k), group_max[k], 1'b0)};
               if (k + 1 < LEVELS) begin
                  if (group_max[k] > group_max[k+1]) group_max[k+1] = group_max[k];
                  group_fill[k+1]++;
               end
            end
            group_max[k]  = '0;
            group_fill[k] = 0;
         end
         burst = {burst, make_result(LEVEL_ENV, stream_peak, 1'b1)};
         clear_stream_state();
         streams_closed++;
      end
      if (burst.size() > 0) burst[burst.size()-1].last_of_run = 1'b1;
      pending_envelopes = {pending_envelopes, burst};
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, what);
   endtask

   function automatic int pick_delay();
      int roll;
      if (!allow_idling) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Random receiver stalls; mostly short, a few long enough to fill the result queue.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (allow_idling && $urandom_range(0, 99) < 25) begin
         stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(10, 40);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.level_index    = rsp_ch.level_index;
         got.max_value      = rsp_ch.max_value;
         got.is_peak_report = rsp_ch.is_peak_report;
         got.last_of_run    = rsp_ch.last_of_run;
         if (pending_envelopes.size() == 0) begin
            report_mismatch($sformatf("unexpected beat level %0d value %0d peak %0b last %0b",
                                      got.level_index, got.max_value, got.is_peak_report,
                                      got.last_of_run));
         end else begin
            want = pending_envelopes.pop_front();
            if (got.level_index !== want.level_index || got.max_value !== want.max_value ||
                got.is_peak_report !== want.is_peak_report ||
                got.last_of_run !== want.last_of_run) begin
               report_mismatch($sformatf(
                  "got level %0d value %0d peak %0b last %0b, wanted %0d %0d %0b %0b",
                  got.level_index, got.max_value, got.is_peak_report, got.last_of_run,
                  want.level_index, want.max_value, want.is_peak_report, want.last_of_run));
            end
         end
         beats_checked++;
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat on any channel for %0d cycles, %0d results outstanding.",
                  WATCHDOG_LIMIT, pending_envelopes.size());
         $display("audio_envelope_peak_pyramid verification failed");
         $finish;
      end
   end

   // Sends one sample; valid stays high into the next call unless that call idles first.
   task automatic send_sample(input logic [SAMPLE_W-1:0] bits, input logic eos);
      int gap;
      gap = pick_delay();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.sample        <= bits;
      req_ch.end_of_stream <= eos;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_sample(bits, eos);
      samples_sent++;
   endtask

   // Drops valid, waits for every expected result, then lets the level row settle.
   task automatic settle_outputs();
      req_ch.valid <= 1'b0;
      while (pending_envelopes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ratio(input logic [RATIO_W-1:0] value);
      settle_outputs();
      csr_ch.valid            <= 1'b1;
      csr_ch.decimation_ratio <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      ratio_reg = value;
      ratio_writes++;
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return SAMPLE_W'($urandom_range(0, 15));
         4: return 16'hFFFF - SAMPLE_W'($urandom_range(0, 15));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // A run of random samples, optionally closed by end of stream.
   task automatic send_run(input int count, input bit close_stream);
      for (int i = 0; i < count; i++) begin
         send_sample(pick_sample(), close_stream && (i == count - 1));
      end
   endtask

   task automatic test_sample_extremes();
      logic [SAMPLE_W-1:0] corners [7];
      corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
      foreach (corners[i]) send_sample(corners[i], 1'b1);
   endtask

   task automatic test_partial_line();
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h8001, 1'b0);
      send_sample(16'h1234, 1'b0);
      send_sample(16'hFF00, 1'b0);
      send_sample(16'h00FF, 1'b1);
   endtask

   // Ratios below 2 and above 16 are clamped; short streams only see the flush path.
   task automatic test_ratio_settings();
      logic [RATIO_W-1:0] settings [5];
      settings = '{5'd0, 5'd17, 5'd31, 5'd2, 5'd16};
      foreach (settings[i]) begin
         write_ratio(settings[i]);
         send_run(2, 1'b1);
      end
   endtask

   task automatic test_random_streams();
      int issued;
      int len;
      int roll;
      issued = 0;
      while (issued < RANDOM_SAMPLES) begin
         allow_idling = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 3) == 0) write_ratio(RATIO_W'($urandom_range(0, 31)));
         roll = $urandom_range(0, 9);
         if (roll < 7) len = $urandom_range(1, 8);
         else if (roll < 9) len = $urandom_range(9, 40);
         else len = $urandom_range(41, 120);
         if (len > RANDOM_SAMPLES - issued) len = RANDOM_SAMPLES - issued;
         // About one stream in six runs on without end of stream into the next one.
         send_run(len, $urandom_range(0, 5) != 0);
         issued += len;
      end
      allow_idling = 1'b1;
      send_run(1, 1'b1);
   endtask

   initial begin
      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      req_ch.sample           <= '0;
      req_ch.end_of_stream    <= 1'b0;
      csr_ch.valid            <= 1'b0;
      csr_ch.decimation_ratio <= '0;
      ratio_reg = RATIO_RESET;
      clear_stream_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sample_extremes();
      test_partial_line();
      test_ratio_settings();
      test_random_streams();
      settle_outputs();

      $display("Sent %0d samples in %0d closed streams with %0d ratio writes;",
               samples_sent, streams_closed, ratio_writes);
      $display("checked %0d result beats, %0d mismatches.", beats_checked, error_count);
      if (error_count == 0) begin
         $display("audio_envelope_peak_pyramid verification clean");
      end else begin
         $display("audio_envelope_peak_pyramid verification failed");
      end
      $finish;
   end

endmodule
